// ===== rtl/hrvw_pkg.sv =====
// Package for the HRV sliding-window block: action codes and arithmetic unit widths.
// Used by the ring memory, the divider, the square-root unit and the top level; no dependencies.
`default_nettype none
package hrvw_pkg;

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_PRUNE = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_CLEAR = 2'd3
	} act_t;

	localparam int unsigned OPW  = 64;  // operand width of divider and square root
	localparam int unsigned RTW  = 32;  // square root width
	localparam int unsigned DVW  = 16;  // divisor width
	localparam int unsigned TSW  = 32;  // beat timestamp width
	localparam int unsigned RRW  = 16;  // RR interval width
	localparam int unsigned RMW  = 16;  // RMSSD width
	localparam int unsigned SDW  = 15;  // SDNN width

endpackage
`default_nettype wire

// ===== rtl/hrvw_ring_mem.sv =====
// Beat ring storage: timestamp and RR interval per entry, one write and one read port.
// Read data is registered. Uses hrvw_pkg widths.
`default_nettype none
module hrvw_ring_mem #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  wire                                  clk,
	input  wire                                  we,
	input  wire  [AW-1:0]                        waddr,
	input  wire  [hrvw_pkg::TSW+hrvw_pkg::RRW-1:0] wdata,
	input  wire                                  re,
	input  wire  [AW-1:0]                        raddr,
	output logic [hrvw_pkg::TSW+hrvw_pkg::RRW-1:0] rdata
);

	logic [hrvw_pkg::TSW+hrvw_pkg::RRW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/hrvw_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend over 16-bit divisor.
// Uses hrvw_pkg widths.
`default_nettype none
module hrvw_div (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire  [hrvw_pkg::OPW-1:0]   dividend,
	input  wire  [hrvw_pkg::DVW-1:0]   divisor,
	output logic [hrvw_pkg::OPW-1:0]   quotient,
	output logic                       done
);

	localparam int unsigned CNTW = $clog2(hrvw_pkg::OPW);

	logic [hrvw_pkg::DVW:0]   rem_q;
	logic [hrvw_pkg::DVW-1:0] dv_q;
	logic [CNTW-1:0]          cnt_q;
	logic                     busy_q;
	logic [hrvw_pkg::DVW:0]   rem_sh;
	logic                     fit;

	assign rem_sh = {rem_q[hrvw_pkg::DVW-1:0], quotient[hrvw_pkg::OPW-1]};
	assign fit    = rem_sh >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(hrvw_pkg::OPW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quotient <= dividend;
			dv_q     <= divisor;
			rem_q    <= '0;
		end else if (busy_q) begin
			rem_q    <= fit ? (rem_sh - {1'b0, dv_q}) : rem_sh;
			quotient <= {quotient[hrvw_pkg::OPW-2:0], fit};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/hrvw_isqrt.sv =====
// Integer square root, two operand bits per cycle, floor of the root of a 64-bit value.
// Uses hrvw_pkg widths.
`default_nettype none
module hrvw_isqrt (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire  [hrvw_pkg::OPW-1:0]   operand,
	output logic [hrvw_pkg::RTW-1:0]   root,
	output logic                       done
);

	localparam int unsigned CNTW = $clog2(hrvw_pkg::RTW);

	logic [hrvw_pkg::OPW-1:0] v_q;
	logic [hrvw_pkg::RTW+1:0] rem_q;
	logic [CNTW-1:0]          cnt_q;
	logic                     busy_q;
	logic [hrvw_pkg::RTW+1:0] rem_sh;
	logic [hrvw_pkg::RTW+1:0] trial;
	logic                     fit;

	assign rem_sh = {rem_q[hrvw_pkg::RTW-1:0], v_q[hrvw_pkg::OPW-1 -: 2]};
	assign trial  = {root, 2'b01};
	assign fit    = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(hrvw_pkg::RTW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= operand;
			rem_q <= '0;
			root  <= '0;
		end else if (busy_q) begin
			v_q   <= {v_q[hrvw_pkg::OPW-3:0], 2'b00};
			rem_q <= fit ? (rem_sh - trial) : rem_sh;
			root  <= {root[hrvw_pkg::RTW-2:0], fit};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/hrv_window_rmssd_sdnn_core.sv =====
// HRV sliding window: push and clear go through ST_FIN to load the result; prune alternates
// ST_PR_RD and ST_PR_CMP per dropped beat and ends from ST_PR_RD when the ring runs empty.
// Query with n >= 2 held beats: walk, drain, multiply, term, divide, root, then, unless the term
// is zero, a second root and divide; fewer beats go straight to ST_FIN. Input is taken again
// the cycle after the result loads. Asynchronous active-low reset empties the ring and sets
// window_ms to 300000; the ring memory itself is not cleared, only entries written since are read.
`default_nettype none
module hrv_window_rmssd_sdnn_core #(
	parameter int unsigned RING_DEPTH = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	// window_ms register
	input  wire         cfg_wr_en,
	input  wire  [31:0] cfg_wr_data,
	// input stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // [31:0] time_ms, [47:32] rr_ms
	input  wire  [1:0]  s_tuser,   // [1:0] action
	// result stream
	output logic        m_tvalid,
	input  wire         m_tready,
	// [15:0] rmssd_ms, [30:16] sdnn_ms, then beat_count, zero padded
	output logic [((31 + $clog2(RING_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int unsigned PW  = $clog2(RING_DEPTH);
	localparam int unsigned CW  = $clog2(RING_DEPTH + 1);
	localparam int unsigned OW  = ((31 + CW + 7) / 8) * 8;
	localparam int unsigned SW  = 32 + CW;               // sum of squares
	localparam int unsigned TW  = hrvw_pkg::RRW + CW;    // sum of RR
	localparam int unsigned MW  = 2 * TW;                // n*Q and T*T
	localparam int unsigned MEMW = hrvw_pkg::TSW + hrvw_pkg::RRW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PR_RD, ST_PR_CMP, ST_WALK, ST_DRAIN, ST_MUL, ST_TERM,
		ST_DIV1, ST_SQ1, ST_SQ2, ST_DIV2, ST_FIN
	} state_t;

	state_t state_q;

	logic [31:0]  window_q;
	logic [PW-1:0] wr_ptr_q, old_ptr_q, walk_ptr_q;
	logic [CW-1:0] held_q, walk_left_q;
	logic [31:0]  time_q;
	logic [hrvw_pkg::RMW-1:0] rmssd_q;
	logic [hrvw_pkg::SDW-1:0] sdnn_q;
	logic         term_zero_q;
	logic [MW-1:0] nq_s1, tt_s1, term_q;

	// unit control
	logic                      div_go_q, sq_go_q;
	logic [hrvw_pkg::OPW-1:0]  div_a_q, sq_a_q;
	logic [hrvw_pkg::DVW-1:0]  div_b_q;
	logic [hrvw_pkg::OPW-1:0]  div_quo;
	logic [hrvw_pkg::RTW-1:0]  sq_root;
	logic                      div_done, sq_done;

	// walk pipeline and accumulators
	logic         rd_vld_s1, vld_s2, first_q;
	logic [15:0]  prev_q, v_s2;
	logic [31:0]  dsq_s2, vsq_s2;
	logic [SW-1:0] s_acc_q, q_acc_q;
	logic [TW-1:0] t_acc_q;

	// memory ports
	logic          mem_we, mem_re;
	logic [PW-1:0] mem_raddr;
	logic [MEMW-1:0] mem_rdata;

	logic          in_xfer, out_free;
	hrvw_pkg::act_t act;
	logic [15:0]   cur_rr, diff;
	logic [31:0]   age;

	assign act      = hrvw_pkg::act_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	assign mem_we    = in_xfer && (act == hrvw_pkg::ACT_PUSH);
	assign mem_re    = (state_q == ST_WALK) || (state_q == ST_PR_RD && held_q != '0);
	assign mem_raddr = (state_q == ST_WALK) ? walk_ptr_q : old_ptr_q;

	assign cur_rr = mem_rdata[MEMW-1 -: hrvw_pkg::RRW];
	assign diff   = (cur_rr >= prev_q) ? (cur_rr - prev_q) : (prev_q - cur_rr);
	assign age    = time_q - mem_rdata[hrvw_pkg::TSW-1:0];

	function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
		return (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	hrvw_ring_mem #(.DEPTH(RING_DEPTH), .AW(PW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_ptr_q),
		.wdata ({s_tdata[47:32], s_tdata[31:0]}),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	hrvw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.quotient (div_quo),
		.done     (div_done)
	);

	hrvw_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_go_q),
		.operand (sq_a_q),
		.root    (sq_root),
		.done    (sq_done)
	);

	// Walk pipeline: read, square, accumulate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			vld_s2    <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_WALK);
			vld_s2    <= rd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && act == hrvw_pkg::ACT_QUERY) begin
			first_q <= 1'b1;
			s_acc_q <= '0;
			q_acc_q <= '0;
			t_acc_q <= '0;
		end else begin
			if (rd_vld_s1) begin
				dsq_s2  <= first_q ? 32'd0 : diff * diff;
				vsq_s2  <= cur_rr * cur_rr;
				v_s2    <= cur_rr;
				prev_q  <= cur_rr;
				first_q <= 1'b0;
			end
			if (vld_s2) begin
				s_acc_q <= s_acc_q + SW'(dsq_s2);
				q_acc_q <= q_acc_q + SW'(vsq_s2);
				t_acc_q <= t_acc_q + TW'(v_s2);
			end
		end
	end

	// Control sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= 32'd300000;
			wr_ptr_q    <= '0;
			old_ptr_q   <= '0;
			held_q      <= '0;
			m_tvalid    <= 1'b0;
			div_go_q    <= 1'b0;
			sq_go_q     <= 1'b0;
			walk_ptr_q  <= '0;
			walk_left_q <= '0;
		end else begin
			div_go_q <= 1'b0;
			sq_go_q  <= 1'b0;
			if (cfg_wr_en) begin
				window_q <= cfg_wr_data;
			end
			// drop the result once taken, unless the next one loads in this cycle
			if (m_tvalid && m_tready && state_q != ST_FIN) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						time_q  <= s_tdata[31:0];
						rmssd_q <= '0;
						sdnn_q  <= '0;
						unique case (act)
							hrvw_pkg::ACT_PUSH: begin
								wr_ptr_q <= next_slot(wr_ptr_q);
								if (held_q != CW'(RING_DEPTH)) begin
									held_q <= held_q + 1'b1;
								end else begin
									old_ptr_q <= next_slot(old_ptr_q);
								end
								state_q <= ST_FIN;
							end
							hrvw_pkg::ACT_PRUNE: state_q <= ST_PR_RD;
							hrvw_pkg::ACT_QUERY: begin
								walk_ptr_q  <= old_ptr_q;
								walk_left_q <= held_q;
								state_q     <= (held_q < CW'(2)) ? ST_FIN : ST_WALK;
							end
							hrvw_pkg::ACT_CLEAR: begin
								wr_ptr_q  <= '0;
								old_ptr_q <= '0;
								held_q    <= '0;
								state_q   <= ST_FIN;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_PR_RD: begin
					state_q <= (held_q == '0) ? ST_FIN : ST_PR_CMP;
				end
				ST_PR_CMP: begin
					// drop the oldest beat while it is older than the window
					if (age > window_q) begin
						old_ptr_q <= next_slot(old_ptr_q);
						held_q    <= held_q - 1'b1;
						state_q   <= ST_PR_RD;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_WALK: begin
					walk_ptr_q  <= next_slot(walk_ptr_q);
					walk_left_q <= walk_left_q - 1'b1;
					if (walk_left_q == CW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_vld_s1 && !vld_s2) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					nq_s1   <= MW'(held_q) * MW'(q_acc_q);
					tt_s1   <= MW'(t_acc_q) * MW'(t_acc_q);
					state_q <= ST_TERM;
				end
				ST_TERM: begin
					term_zero_q <= (nq_s1 <= tt_s1);
					term_q      <= nq_s1 - tt_s1;
					div_a_q     <= hrvw_pkg::OPW'(s_acc_q);
					div_b_q     <= hrvw_pkg::DVW'(held_q - 1'b1);
					div_go_q    <= 1'b1;
					state_q     <= ST_DIV1;
				end
				ST_DIV1: begin
					if (div_done) begin
						sq_a_q  <= div_quo;
						sq_go_q <= 1'b1;
						state_q <= ST_SQ1;
					end
				end
				ST_SQ1: begin
					if (sq_done) begin
						rmssd_q <= sq_root[hrvw_pkg::RMW-1:0];
						if (term_zero_q) begin
							state_q <= ST_FIN;
						end else begin
							sq_a_q  <= hrvw_pkg::OPW'(term_q);
							sq_go_q <= 1'b1;
							state_q <= ST_SQ2;
						end
					end
				end
				ST_SQ2: begin
					if (sq_done) begin
						div_a_q  <= hrvw_pkg::OPW'(sq_root);
						div_b_q  <= hrvw_pkg::DVW'(held_q);
						div_go_q <= 1'b1;
						state_q  <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						sdnn_q  <= div_quo[hrvw_pkg::SDW-1:0];
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hand the result to the output register once it is free
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= OW'({held_q, sdnn_q, rmssd_q});
						state_q  <= ST_IDLE;
					end else if (m_tvalid && m_tready) begin
						m_tvalid <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_held_max: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(RING_DEPTH))
		else $error("held count above ring depth");

	a_ptr_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		((32'(old_ptr_q) + 32'(held_q)) % RING_DEPTH) == 32'(wr_ptr_q))
		else $error("write pointer out of step with oldest pointer and count");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && act == hrvw_pkg::ACT_CLEAR) |=> (held_q == '0))
		else $error("clear left beats in the ring");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && act == hrvw_pkg::ACT_PUSH && held_q != CW'(RING_DEPTH))
		|=> (held_q == $past(held_q) + 1'b1))
		else $error("push did not add a beat");

	a_walk_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (held_q >= CW'(2)))
		else $error("metric walk with fewer than two beats");
`endif

endmodule
`default_nettype wire
